// ===== src/assert_macros.svh =====
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons)

`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 11;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [FUNC_W-1:0]        func_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic [OCC_W-1:0]         occ_type;

   localparam func_type FUNC_PUSH = 2'd0;
   localparam func_type FUNC_POP  = 2'd1;
   localparam func_type FUNC_PEEK = 2'd2;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request fields
      logic execute;  // apply request to pointers and memory
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Double-ended queue on a ring buffer of DEPTH 32-bit entries.
// A taken request is captured, applied in the execute state, then shown with rsp_valid.
// No request is taken while busy is high; a new one may be taken while a result is shown.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset (synchronous): queue empty, front at slot 0; memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue #(
   parameter int DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire dq_pkg::func_type     req_func,
   input  wire logic                 req_at_back,
   input  wire dq_pkg::data_type     req_push_value,
   output logic                      rsp_valid,
   output dq_pkg::status_type        rsp_status,
   output dq_pkg::data_type          rsp_peek_value,
   output dq_pkg::occ_type           rsp_occupancy
);

   dq_pkg::cmd_type cmd;

   logic rsp_full;
   logic rsp_failed;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_at_back    (req_at_back),
      .req_push_value (req_push_value),
      .rsp_status     (rsp_status),
      .rsp_peek_value (rsp_peek_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   assign rsp_full   = rsp_valid && (rsp_status == dq_pkg::ST_FULL);
   assign rsp_failed = rsp_valid && (rsp_status != dq_pkg::ST_DONE);

   `ASSERT_NEXT_CYCLE(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_NEXT_CYCLE(a_exec_resp, clock, reset, busy, rsp_valid && !busy)
   `ASSERT_SAME_CYCLE(a_full_occ, clock, reset, rsp_full, rsp_occupancy == dq_pkg::OCC_W'(DEPTH))
   `ASSERT_SAME_CYCLE(a_fail_zero, clock, reset, rsp_failed, rsp_peek_value == '0)

endmodule

`default_nettype wire

// ===== src/dq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_valid,
   output dq_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // a new request may be taken while the result is shown
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load    = accept;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_valid   = (state_ff == ST_RESP);

endmodule

`default_nettype wire

// ===== src/dq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath #(
   parameter int DEPTH = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dq_pkg::cmd_type      cmd,
   input  wire dq_pkg::func_type     req_func,
   input  wire logic                 req_at_back,
   input  wire dq_pkg::data_type     req_push_value,
   output dq_pkg::status_type        rsp_status,
   output dq_pkg::data_type          rsp_peek_value,
   output dq_pkg::occ_type           rsp_occupancy
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

   // captured request
   dq_pkg::func_type func_ff;
   logic             at_back_ff;
   dq_pkg::data_type value_ff;

   // queue state
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;

   // result registers
   dq_pkg::status_type status_ff, status_in;
   dq_pkg::occ_type    occ_ff;
   logic               peek_ok_ff, peek_ok_in;
   logic [dq_pkg::DATA_W-1:0] rd_data_ff;

   logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

   logic          empty, full;
   logic [SW-1:0] tail_sum;
   logic [IW-1:0] tail_idx, back_idx, front_dec, front_inc;
   logic          wr_en, rd_en;
   logic [IW-1:0] mem_addr;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == DEPTH_C);

   // slot after the back entry: (front + count) mod DEPTH, sum below 2*DEPTH
   assign tail_sum  = SW'(front_ff) + SW'(count_ff);
   assign tail_idx  = (tail_sum >= DEPTH_S) ? IW'(tail_sum - DEPTH_S) : IW'(tail_sum);
   assign back_idx  = (tail_idx == '0) ? LAST_IDX : IW'(tail_idx - 1'b1);
   assign front_dec = (front_ff == '0) ? LAST_IDX : IW'(front_ff - 1'b1);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : IW'(front_ff + 1'b1);

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      status_in  = dq_pkg::ST_DONE;
      peek_ok_in = 1'b0;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      mem_addr   = front_ff;
      unique case (func_ff)
         dq_pkg::FUNC_PUSH: begin
            if (full) begin
               status_in = dq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = CW'(count_ff + 1'b1);
               if (at_back_ff) begin
                  mem_addr = tail_idx;
               end else begin
                  mem_addr = front_dec;
                  front_in = front_dec;
               end
            end
         end
         dq_pkg::FUNC_POP: begin
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               count_in = CW'(count_ff - 1'b1);
               if (!at_back_ff) front_in = front_inc;
            end
         end
         dq_pkg::FUNC_PEEK: begin
            if (empty) begin
               status_in = dq_pkg::ST_EMPTY;
            end else begin
               rd_en      = 1'b1;
               peek_ok_in = 1'b1;
               mem_addr   = at_back_ff ? back_idx : front_ff;
            end
         end
         default: begin
            // unused code: no change, reports done
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         at_back_ff <= req_at_back;
         value_ff   <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.execute) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         peek_ok_ff <= peek_ok_in;
         occ_ff     <= dq_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) mem[mem_addr] <= value_ff;
      if (cmd.execute && rd_en) rd_data_ff <= mem[mem_addr];
   end

   assign rsp_status     = status_ff;
   assign rsp_peek_value = peek_ok_ff ? dq_pkg::data_type'(rd_data_ff) : '0;
   assign rsp_occupancy  = occ_ff;

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_test;

   localparam int DEPTH       = 1024;
   localparam int IDX_W       = 10;
   localparam int CYCLE_LIMIT = 500000;

   localparam dq_pkg::func_type FUNC_UNUSED = 2'd3;

   typedef struct packed {
      dq_pkg::status_type status;
      dq_pkg::data_type   peek_value;
      dq_pkg::occ_type    occupancy;
   } queue_response_type;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   dq_pkg::func_type   req_func;
   logic               req_at_back;
   dq_pkg::data_type   req_push_value;
   logic               rsp_valid;
   dq_pkg::status_type rsp_status;
   dq_pkg::data_type   rsp_peek_value;
   dq_pkg::occ_type    rsp_occupancy;

   // queue image kept in step with the block
   dq_pkg::data_type  ring_image [DEPTH];
   logic [IDX_W-1:0]  front_slot = '0;
   int unsigned       held_count = 0;

   queue_response_type pending_responses[$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   bit                 sender_gaps = 1'b1;

   double_ended_queue dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_at_back    (req_at_back),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_peek_value (rsp_peek_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** double_ended_queue: FAILED **");
         $finish;
      end
   end

   function automatic queue_response_type step_queue_image(dq_pkg::func_type f, logic at_back,
                                                           dq_pkg::data_type v);
      queue_response_type r;
      logic [IDX_W-1:0]   slot;
      r.status     = dq_pkg::ST_DONE;
      r.peek_value = '0;
      case (f)
         dq_pkg::FUNC_PUSH: begin
            if (held_count >= DEPTH) begin
               r.status = dq_pkg::ST_FULL;
            end else if (at_back) begin
               slot = front_slot + IDX_W'(held_count);
               ring_image[slot] = v;
               held_count++;
            end else begin
               front_slot = front_slot - 1'b1;
               ring_image[front_slot] = v;
               held_count++;
            end
         end
         dq_pkg::FUNC_POP: begin
            if (held_count == 0) begin
               r.status = dq_pkg::ST_EMPTY;
            end else begin
               if (!at_back)
                  front_slot = front_slot + 1'b1;
               held_count--;
            end
         end
         dq_pkg::FUNC_PEEK: begin
            if (held_count == 0) begin
               r.status = dq_pkg::ST_EMPTY;
            end else begin
               slot = at_back ? front_slot + IDX_W'(held_count) - 1'b1 : front_slot;
               r.peek_value = ring_image[slot];
            end
         end
         default: ;
      endcase
      r.occupancy = dq_pkg::occ_type'(held_count);
      return r;
   endfunction

   // one request transfer; start stays high on return
   task automatic issue_request(dq_pkg::func_type f, logic at_back, dq_pkg::data_type v);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_func       <= f;
      req_at_back    <= at_back;
      req_push_value <= v;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      pending_responses.push_back(step_queue_image(f, at_back, v));
   endtask

   task automatic wait_responses_drained();
      start <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   function automatic dq_pkg::data_type pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return -32'sd1;
         default: return dq_pkg::data_type'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      queue_response_type want;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_peek_value !== want.peek_value) begin
               $error("peek_value: expected %0d, got %0d", want.peek_value, rsp_peek_value);
               error_count++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_queue();
      issue_request(dq_pkg::FUNC_POP, 1'b0, 32'sh7FFF_FFFF);
      issue_request(dq_pkg::FUNC_POP, 1'b1, 32'sh8000_0000);
      issue_request(dq_pkg::FUNC_PEEK, 1'b0, -32'sd1);
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(FUNC_UNUSED, 1'b0, -32'sd1);
   endtask

   task automatic test_both_ends();
      issue_request(dq_pkg::FUNC_PUSH, 1'b1, 32'sh7FFF_FFFF);
      issue_request(dq_pkg::FUNC_PUSH, 1'b0, 32'sh8000_0000);
      issue_request(dq_pkg::FUNC_PUSH, 1'b1, -32'sd1);
      issue_request(dq_pkg::FUNC_PUSH, 1'b0, '0);
      issue_request(dq_pkg::FUNC_PEEK, 1'b0, -32'sd1);
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(FUNC_UNUSED, 1'b1, -32'sd1);
      issue_request(dq_pkg::FUNC_POP, 1'b1, -32'sd1);
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(dq_pkg::FUNC_POP, 1'b0, '0);
      issue_request(dq_pkg::FUNC_PEEK, 1'b0, '0);
      issue_request(dq_pkg::FUNC_POP, 1'b0, '0);
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(dq_pkg::FUNC_POP, 1'b1, '0);
      issue_request(dq_pkg::FUNC_POP, 1'b1, '0);
      issue_request(dq_pkg::FUNC_PEEK, 1'b0, '0);
   endtask

   // fill to the last slot, bounce off full, then pop a few back off
   task automatic test_fill_and_drain();
      wait_responses_drained();
      repeat (DEPTH) issue_request(dq_pkg::FUNC_PUSH, 1'($urandom), pick_value());
      issue_request(dq_pkg::FUNC_PUSH, 1'b0, 32'sh7FFF_FFFF);
      issue_request(dq_pkg::FUNC_PUSH, 1'b1, 32'sh8000_0000);
      issue_request(dq_pkg::FUNC_PEEK, 1'b0, '0);
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(FUNC_UNUSED, 1'b0, '0);
      repeat (DEPTH / 32) begin
         if ($urandom_range(0, 7) == 0)
            issue_request(dq_pkg::FUNC_PEEK, 1'($urandom), pick_value());
         issue_request(dq_pkg::FUNC_POP, 1'($urandom), pick_value());
      end
      issue_request(dq_pkg::FUNC_PEEK, 1'b1, '0);
      issue_request(dq_pkg::FUNC_POP, 1'b0, '0);
   endtask

   task automatic test_random_traffic(int num_items, bit with_gaps);
      traffic_mix_type  mix;
      int               left_in_mix;
      int               roll;
      dq_pkg::func_type f;
      sender_gaps = with_gaps;
      left_in_mix = 0;
      mix         = MIX_EVEN;
      for (int i = 0; i < num_items; i++) begin
         if (left_in_mix == 0) begin
            mix         = traffic_mix_type'($urandom_range(0, 2));
            left_in_mix = $urandom_range(20, 80);
         end
         left_in_mix--;
         roll = $urandom_range(0, 99);
         if (roll < 3)
            f = FUNC_UNUSED;
         else if (mix == MIX_FILL)
            f = (roll < 70) ? dq_pkg::FUNC_PUSH : (roll < 85) ? dq_pkg::FUNC_POP
                                                               : dq_pkg::FUNC_PEEK;
         else if (mix == MIX_DRAIN)
            f = (roll < 18) ? dq_pkg::FUNC_PUSH : (roll < 80) ? dq_pkg::FUNC_POP
                                                               : dq_pkg::FUNC_PEEK;
         else
            f = (roll < 38) ? dq_pkg::FUNC_PUSH : (roll < 70) ? dq_pkg::FUNC_POP
                                                               : dq_pkg::FUNC_PEEK;
         issue_request(f, 1'($urandom), pick_value());
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= dq_pkg::FUNC_PUSH;
      req_at_back    <= 1'b0;
      req_push_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_both_ends();
      test_fill_and_drain();
      test_random_traffic(80, 1'b1);
      test_random_traffic(40, 1'b0);

      wait_responses_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("** double_ended_queue: PASSED **");
      else
         $display("** double_ended_queue: FAILED **");
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
+incdir+src
src/dq_pkg.sv
src/dq_ctrl.sv
src/dq_datapath.sv
src/double_ended_queue.sv
tb/double_ended_queue_test.sv
